// File: rtl/core/line_fold_word_wrap_macros.svh
// Assertion helpers for the line folding block.
// LFW_ASSERT_IMPL:  same-cycle implication.
// LFW_ASSERT_NEXT:  implication checked in the next cycle.
`ifndef LINE_FOLD_WORD_WRAP_MACROS_SVH
`define LINE_FOLD_WORD_WRAP_MACROS_SVH

`ifndef SYNTHESIS
`define LFW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line fold check failed");
`define LFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line fold check failed");
`else
`define LFW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LFW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/lfw_pkg.sv
`timescale 1ns / 1ps

package lfw_pkg;

    // Line geometry
    localparam int LINE_WIDTH = 10;
    localparam int TAB_STOP   = 8;

    localparam int ADDR_W = $clog2(LINE_WIDTH);
    localparam int CNT_W  = $clog2(LINE_WIDTH + 1);
    localparam int CHAR_W = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LINE_WIDTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(LINE_WIDTH);

    // Bit i set when column i sits on a tab stop
    function automatic logic [LINE_WIDTH:0] f_tab_mask();
        logic [LINE_WIDTH:0] m;
        m = '0;
        for (int i = 0; i <= LINE_WIDTH; i++) begin
            m[i] = ((i % TAB_STOP) == 0);
        end
        return m;
    endfunction

    localparam logic [LINE_WIDTH:0] TAB_MASK = f_tab_mask();

    // Line store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } t_ram_wr;

    // One character handed to the output stage
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] data;
        logic              last;
    } t_emit;

endpackage

// File: rtl/core/lfw_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read, write data forwarded on address match
module lfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lfw_out.sv
`timescale 1ns / 1ps

// Output register: holds one item until the sink takes it
module lfw_out
    import lfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_emit             i_emit,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [CHAR_W-1:0] o_tdata,
    output logic              o_tlast
);

    logic              r_valid;
    logic [CHAR_W-1:0] r_data;
    logic              r_last;

    assign o_free = !r_valid || i_tready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_emit.valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_emit.valid) begin
            r_data <= i_emit.data;
            r_last <= i_emit.last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

// File: rtl/core/lfw_ctrl.sv
`timescale 1ns / 1ps
`include "line_fold_word_wrap_macros.svh"

// Sequencer: tab fill, blank search, line emit and remainder shift, all
// through the single read and write port of the line store
module lfw_ctrl
    import lfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_char,
    output t_ram_wr           o_ram,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [CHAR_W-1:0] i_rdata,
    output t_emit             o_emit,
    input  logic              i_emit_free
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAB   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_fill,  n_fill;
    logic [ADDR_W-1:0] r_rd,    n_rd;     // store read pointer
    logic [ADDR_W-1:0] r_wp,    n_wp;     // store write pointer
    logic [CNT_W-1:0]  r_cnt,   n_cnt;    // columns to emit
    logic [CNT_W-1:0]  r_pos,   n_pos;    // columns emitted so far
    logic              r_shift, n_shift;  // remainder to move after emit

    logic             accept;
    logic [CNT_W-1:0] tab_next;
    logic [CNT_W-1:0] cut;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign tab_next = CNT_W'(r_wp) + CNT_W'(1);
    assign cut      = CNT_W'(r_rd) + CNT_W'(1);
    // read data always shows the entry at r_rd
    assign o_raddr  = n_rd;

    // Next state and datapath control
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rd    = r_rd;
        n_wp    = r_wp;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_shift = r_shift;
        o_ram   = '0;
        o_emit  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_char)
                        CH_TAB: begin
                            n_wp    = r_fill[ADDR_W-1:0];
                            n_state = S_TAB;
                        end
                        CH_NL: begin
                            if (r_fill != '0) begin
                                n_rd    = '0;
                                n_pos   = '0;
                                n_cnt   = r_fill;
                                n_shift = 1'b0;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            o_ram.we   = 1'b1;
                            o_ram.addr = r_fill[ADDR_W-1:0];
                            o_ram.data = i_char;
                            if (r_fill == FULL_CNT - CNT_W'(1)) begin
                                n_rd    = LAST_ADDR;
                                n_state = S_SRCH;
                            end else begin
                                n_fill = r_fill + CNT_W'(1);
                            end
                        end
                    endcase
                end
            end

            // one blank per cycle up to the next tab stop or the line end
            S_TAB: begin
                o_ram.we   = 1'b1;
                o_ram.addr = r_wp;
                o_ram.data = CH_BLANK;
                if (tab_next == FULL_CNT) begin
                    n_rd    = '0;
                    n_pos   = '0;
                    n_cnt   = FULL_CNT;
                    n_shift = 1'b0;
                    n_state = S_EMIT;
                end else if (TAB_MASK[tab_next]) begin
                    n_fill  = tab_next;
                    n_state = S_IDLE;
                end else begin
                    n_wp = r_wp + ADDR_W'(1);
                end
            end

            // walk back from the last column looking for a blank
            S_SRCH: begin
                if (r_rd != '0 && i_rdata == CH_BLANK) begin
                    n_cnt   = cut;
                    n_shift = (cut != FULL_CNT);
                    n_rd    = '0;
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else if (r_rd == '0) begin
                    n_cnt   = FULL_CNT;
                    n_shift = 1'b0;
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_rd = r_rd - ADDR_W'(1);
                end
            end

            // stored columns, then the newline
            S_EMIT: begin
                if (i_emit_free) begin
                    o_emit.valid = 1'b1;
                    if (r_pos != r_cnt) begin
                        o_emit.data = i_rdata;
                        o_emit.last = 1'b0;
                        n_pos       = r_pos + CNT_W'(1);
                        if (r_rd != LAST_ADDR) begin
                            n_rd = r_rd + ADDR_W'(1);
                        end
                    end else begin
                        o_emit.data = CH_NL;
                        o_emit.last = 1'b1;
                        if (r_shift) begin
                            // r_rd already sits at the cut column
                            n_wp    = '0;
                            n_state = S_SHIFT;
                        end else begin
                            n_fill  = '0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            // move the tail of the line to the front
            S_SHIFT: begin
                o_ram.we   = 1'b1;
                o_ram.addr = r_wp;
                o_ram.data = i_rdata;
                if (r_rd == LAST_ADDR) begin
                    n_fill  = CNT_W'(r_wp) + CNT_W'(1);
                    n_state = S_IDLE;
                end else begin
                    n_rd = r_rd + ADDR_W'(1);
                    n_wp = r_wp + ADDR_W'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Pointers and counts
    always_ff @(posedge i_clk) begin
        r_rd    <= n_rd;
        r_wp    <= n_wp;
        r_cnt   <= n_cnt;
        r_pos   <= n_pos;
        r_shift <= n_shift;
    end

    `LFW_ASSERT_IMPL(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill < FULL_CNT)
    `LFW_ASSERT_IMPL(a_emit_count, i_clk, i_rst_n, r_state == S_EMIT, (r_cnt != '0) && (r_pos <= r_cnt) && (r_cnt <= FULL_CNT))
    `LFW_ASSERT_IMPL(a_shift_order, i_clk, i_rst_n, r_state == S_SHIFT, r_wp < r_rd)
    `LFW_ASSERT_NEXT(a_no_blank, i_clk, i_rst_n, r_state == S_SRCH && r_rd == '0, r_state == S_EMIT && r_cnt == FULL_CNT && !r_shift)

endmodule

// File: rtl/core/line_fold_word_wrap.sv
`timescale 1ns / 1ps

// Folds a character stream into lines of at most LINE_WIDTH columns, one
// character per input item. Tabs expand to blanks up to the next TAB_STOP
// column; a newline flushes the stored line plus a newline (nothing when the
// line is empty); a full line is cut after its last blank (column 1 or later)
// or emitted whole, and o_m_axis_tlast marks the final item caused by each
// input. Text still held at end of input is not flushed. One input is worked
// on at a time and every step goes through the single read and write port of
// the line store: a plain character is written in place, a tab writes blanks
// up to the next tab stop (and emits the full line when it reaches the line
// end), a newline emits the stored columns and the newline, and a character
// that fills the line runs the blank search, emits the line up to the cut and
// shifts any remainder to the front. Output backpressure stalls the emit
// steps. A finished item waits in the output register while the next input
// is accepted.
module line_fold_word_wrap
    import lfw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [CHAR_W-1:0] i_s_axis_tdata,   // [7:0] in_char
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [CHAR_W-1:0] o_m_axis_tdata,   // [7:0] out_char
    output logic              o_m_axis_tlast    // last_of_run
);

    t_ram_wr           ram_wr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;
    t_emit             emit;
    logic              emit_free;

    // Sequencer
    lfw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_char      (i_s_axis_tdata),
        .o_ram       (ram_wr),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata),
        .o_emit      (emit),
        .i_emit_free (emit_free)
    );

    // Line store
    lfw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_WIDTH),
        .AW    (ADDR_W)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register
    lfw_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_emit   (emit),
        .o_free   (emit_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
